// File: hw/rtl/throttle_link_slew_limiter_assert.svh
// Assertion macros shared by the slew limiter RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef THROTTLE_LINK_SLEW_LIMITER_ASSERT_SVH
`define THROTTLE_LINK_SLEW_LIMITER_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define TLS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define TLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define TLS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/tls_pkg.sv
// Package for the throttle link slew limiter: widths, register map, reset values,
// interface structs and the divide-by-255 helper. No dependencies.
package tls_pkg;

    localparam int TIME_W    = 32;
    localparam int PROD_W    = 40;   // elapsed (32b) times command range (8b)
    localparam int SWEEP_W   = 16;
    localparam int STEP_W    = 16;
    localparam int CMD_W     = 8;
    localparam int TGT_W     = 9;    // min_command plus scaled throttle
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int IDX_W     = 3;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    // Register indexes (byte address is 4 * index)
    localparam logic [IDX_W-1:0] REG_READ_TIMEOUT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_POWER_TIMEOUT = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_COMMAND   = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_COMMAND   = 3'd3;
    localparam logic [IDX_W-1:0] REG_COMMAND_RANGE = 3'd4;
    localparam logic [IDX_W-1:0] REG_FULL_SWEEP    = 3'd5;
    localparam logic [IDX_W-1:0] REG_RELEASE_MULT  = 3'd6;

    localparam logic [15:0] RST_READ_TIMEOUT  = 16'd500;
    localparam logic [15:0] RST_POWER_TIMEOUT = 16'd1000;
    localparam logic [7:0]  RST_MIN_COMMAND   = 8'd0;
    localparam logic [7:0]  RST_MAX_COMMAND   = 8'd180;
    localparam logic [7:0]  RST_COMMAND_RANGE = 8'd180;
    localparam logic [15:0] RST_FULL_SWEEP    = 16'd2000;
    localparam logic [3:0]  RST_RELEASE_MULT  = 4'd2;

    typedef struct packed {
        logic [15:0]        read_timeout_ms;
        logic [15:0]        power_timeout_ms;
        logic [CMD_W-1:0]   min_command;
        logic [CMD_W-1:0]   max_command;
        logic [7:0]         command_range;
        logic [SWEEP_W-1:0] full_sweep_ms;
        logic [3:0]         release_multiplier;
    } cfg_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // floor(x / 255) for x up to 255 * 255, by reciprocal with correction
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] sum;
        begin
            sum = x + {8'd0, x[15:8]} + 16'd1;
            return sum[15:8];
        end
    endfunction

endpackage

// File: hw/rtl/tls_cfg.sv
// APB-style configuration register file for the slew limiter.
// Depends on tls_pkg for the register map, reset values and cfg_t.
module tls_cfg
    import tls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[PADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.read_timeout_ms    <= RST_READ_TIMEOUT;
            cfg_reg.power_timeout_ms   <= RST_POWER_TIMEOUT;
            cfg_reg.min_command        <= RST_MIN_COMMAND;
            cfg_reg.max_command        <= RST_MAX_COMMAND;
            cfg_reg.command_range      <= RST_COMMAND_RANGE;
            cfg_reg.full_sweep_ms      <= RST_FULL_SWEEP;
            cfg_reg.release_multiplier <= RST_RELEASE_MULT;
        end else if (wr_en) begin
            unique case (idx)
                REG_READ_TIMEOUT:  cfg_reg.read_timeout_ms    <= pwdata[15:0];
                REG_POWER_TIMEOUT: cfg_reg.power_timeout_ms   <= pwdata[15:0];
                REG_MIN_COMMAND:   cfg_reg.min_command        <= pwdata[7:0];
                REG_MAX_COMMAND:   cfg_reg.max_command        <= pwdata[7:0];
                REG_COMMAND_RANGE: cfg_reg.command_range      <= pwdata[7:0];
                REG_FULL_SWEEP:    cfg_reg.full_sweep_ms      <= pwdata[15:0];
                REG_RELEASE_MULT:  cfg_reg.release_multiplier <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_READ_TIMEOUT:  prdata = {16'd0, cfg_reg.read_timeout_ms};
            REG_POWER_TIMEOUT: prdata = {16'd0, cfg_reg.power_timeout_ms};
            REG_MIN_COMMAND:   prdata = {24'd0, cfg_reg.min_command};
            REG_MAX_COMMAND:   prdata = {24'd0, cfg_reg.max_command};
            REG_COMMAND_RANGE: prdata = {24'd0, cfg_reg.command_range};
            REG_FULL_SWEEP:    prdata = {16'd0, cfg_reg.full_sweep_ms};
            REG_RELEASE_MULT:  prdata = {28'd0, cfg_reg.release_multiplier};
            default:           prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/tls_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tls_pkg for widths and the divider control/status structs.
module tls_div
    import tls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  div_ctrl_t          div_ctrl,
    input  logic [PROD_W-1:0]  dividend,
    input  logic [SWEEP_W-1:0] divisor,
    output div_stat_t          div_stat,
    output logic [PROD_W-1:0]  quotient,
    output logic               rem_nz
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SWEEP_W-1:0]   rem_reg;
    logic [PROD_W-1:0]    quo_reg;

    logic [SWEEP_W:0]     trial;
    logic [SWEEP_W:0]     diff;
    logic                 fits;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ctrl.start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[SWEEP_W-1:0] : trial[SWEEP_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign div_stat.busy = busy_reg;
    assign div_stat.done = done_reg;
    assign quotient      = quo_reg;
    assign rem_nz        = rem_reg != '0;

endmodule

// File: hw/rtl/throttle_link_slew_limiter.sv
// Path from input accept to m_tvalid: multiply, target, 40-step divide, step, finish.
// One item at a time: the shared restoring divider, one quotient bit per
// cycle over the 40-bit slew numerator, keeps the sequencer busy. s_tready is high only when idle.
// A finished item waits in the output register; the next input is taken meanwhile.
// Reset (aresetn, synchronous, active low) clears held throttle, times, command, the
// sequencer and m_tvalid, and loads the configuration registers with their defaults.
module throttle_link_slew_limiter
    import tls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // [7:0] throttle_byte, [39:8] now_ms
    input  logic               s_tuser,   // [0] byte_arrived
    // result items
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // [7:0] motor_command, [8] power_enable,
                                          // [16:9] held_throttle, [23:17] zero
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "throttle_link_slew_limiter_assert.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_LOAD = 6'b000100,
        S_DIV  = 6'b001000,
        S_STEP = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    cfg_t      cfg;
    div_ctrl_t div_ctrl;
    div_stat_t div_stat;

    state_t state_reg, state_next;

    // architectural state
    logic [7:0]        held_reg;
    logic [TIME_W-1:0] last_byte_reg;
    logic [TIME_W-1:0] last_tick_reg;
    logic [CMD_W-1:0]  cmd_reg;

    // per-item working registers
    logic              arrived_reg;
    logic [7:0]        byte_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [TIME_W-1:0] silence_reg;
    logic              power_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TGT_W-1:0]  target_reg;
    logic [STEP_W-1:0] step_reg;

    // output register
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    logic              in_accept;
    logic              out_free;
    logic              fin_go;

    logic [TIME_W-1:0] now_in;
    logic [7:0]        held_new;
    logic [PROD_W-1:0] quotient;
    logic              rem_nz;
    logic [PROD_W:0]   step_ceil;
    logic [STEP_W-1:0] step_base;
    logic [STEP_W+3:0] step_mult;
    logic [STEP_W-1:0] step_new;
    logic [15:0]       held_x_range;
    logic [TGT_W-1:0]  cmd_ext;
    logic [TGT_W-1:0]  cand;
    logic [TGT_W-1:0]  next_cmd;

    tls_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tls_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_ctrl (div_ctrl),
        .dividend (prod_reg),
        .divisor  (cfg.full_sweep_ms),
        .div_stat (div_stat),
        .quotient (quotient),
        .rem_nz   (rem_nz)
    );

    assign s_tready  = state_reg == S_IDLE;
    assign in_accept = s_tvalid & s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fin_go    = (state_reg == S_FIN) && out_free;
    assign now_in    = s_tdata[39:8];

    assign div_ctrl.start = state_reg == S_LOAD;

    // Sequencer: one item walks through every state; finish waits for the output slot
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_accept) state_next = S_MUL;
            S_MUL:  state_next = S_LOAD;
            S_LOAD: state_next = S_DIV;
            S_DIV:  if (div_stat.done) state_next = S_STEP;
            S_STEP: state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Timeout check: a fresh byte restarts the silence; a long silence drops the throttle
    always_comb begin
        held_new = arrived_reg ? byte_reg : held_reg;
        if (silence_reg > {16'd0, cfg.read_timeout_ms}) begin
            held_new = '0;
        end
    end

    // Target: min plus floor(held * range / 255)
    assign held_x_range = {8'd0, held_reg} * {8'd0, cfg.command_range};

    // Step: ceil of the division, zero sweep means an instant slew, then release scaling
    assign step_ceil = {1'b0, quotient} + {{PROD_W{1'b0}}, rem_nz};
    always_comb begin
        if (cfg.full_sweep_ms == '0) begin
            step_base = STEP_MAX;
        end else if (step_ceil > {{(PROD_W + 1 - STEP_W){1'b0}}, STEP_MAX}) begin
            step_base = STEP_MAX;
        end else begin
            step_base = step_ceil[STEP_W-1:0];
        end
        step_mult = {4'd0, step_base} * {{STEP_W{1'b0}}, cfg.release_multiplier};
        if (held_reg != '0) begin
            step_new = step_base;
        end else if (step_mult > {4'd0, STEP_MAX}) begin
            step_new = STEP_MAX;
        end else begin
            step_new = step_mult[STEP_W-1:0];
        end
    end

    // Slew toward the target, bounded by the step and the command limits; power off forces min_command
    assign cmd_ext = {1'b0, cmd_reg};
    always_comb begin
        cand     = cmd_ext;
        next_cmd = cmd_ext;
        if (!power_reg) begin
            next_cmd = {1'b0, cfg.min_command};
        end else if (target_reg > cmd_ext) begin
            if ({7'd0, target_reg - cmd_ext} <= step_reg) begin
                cand = target_reg;
            end else begin
                cand = cmd_ext + step_reg[TGT_W-1:0];
            end
            next_cmd = (cand > {1'b0, cfg.max_command}) ? {1'b0, cfg.max_command} : cand;
        end else if (target_reg < cmd_ext) begin
            if ({7'd0, cmd_ext - target_reg} <= step_reg) begin
                cand = target_reg;
            end else begin
                cand = cmd_ext - step_reg[TGT_W-1:0];
            end
            next_cmd = (cand < {1'b0, cfg.min_command}) ? {1'b0, cfg.min_command} : cand;
        end
    end

    // Architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            last_byte_reg <= '0;
            last_tick_reg <= '0;
            cmd_reg       <= '0;
        end else begin
            if (state_reg == S_MUL) begin
                held_reg <= held_new;
                if (arrived_reg) begin
                    last_byte_reg <= now_reg;
                end
            end
            if (fin_go) begin
                cmd_reg       <= next_cmd[CMD_W-1:0];
                last_tick_reg <= now_reg;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            arrived_reg <= s_tuser;
            byte_reg    <= s_tdata[7:0];
            now_reg     <= now_in;
            elapsed_reg <= now_in - last_tick_reg;
            silence_reg <= s_tuser ? '0 : now_in - last_byte_reg;
        end
        if (state_reg == S_MUL) begin
            prod_reg  <= {{(PROD_W - TIME_W){1'b0}}, elapsed_reg}
                       * {{(PROD_W - 8){1'b0}}, cfg.command_range};
            power_reg <= silence_reg < {16'd0, cfg.power_timeout_ms};
        end
        if (state_reg == S_LOAD) begin
            target_reg <= {1'b0, cfg.min_command} + {1'b0, div255(held_x_range)};
        end
        if (state_reg == S_STEP) begin
            step_reg <= step_new;
        end
    end

    // Output register: load on finish, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            m_tdata_reg <= {7'd0, held_reg, power_reg, next_cmd[CMD_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The divider only finishes while the sequencer waits for it
    `TLS_ASSERT_CLK(a_div_done_in_wait, aclk, aresetn, div_stat.done |-> state_reg == S_DIV, "divider done outside wait state")
    // No item is accepted while the shared divider is running
    `TLS_ASSERT_CLK(a_no_accept_busy, aclk, aresetn, s_tready |-> !div_stat.busy, "ready while divider busy")
    // A finished item always lands in the output register
    `TLS_ASSERT_CLK(a_fin_loads_out, aclk, aresetn, fin_go |=> m_tvalid_reg, "finished item not presented")
    // Reset leaves the sequencer idle
    `TLS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == S_IDLE, "sequencer not idle after reset")

endmodule

// File: dv/tls_checker.sv
`timescale 1ns / 100ps
// Result checker for the throttle link slew limiter: mirrors the registers written on
// the APB port, predicts every result from accepted input items and compares. Uses tls_pkg.
module tls_checker
    import tls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [39:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [23:0]        m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 mismatch_count,
    output int                 open_count
);

    // Same layout as m_tdata[16:0]
    typedef struct packed {
        logic [7:0] held;
        logic       power;
        logic [7:0] command;
    } tick_result_t;

    cfg_t         cfg;
    logic [7:0]   held_thr;
    logic [31:0]  last_byte_ms;
    logic [31:0]  silence_ms;
    logic [31:0]  last_tick_ms;
    logic [7:0]   command;
    tick_result_t pending_results[$];
    int           mismatches = 0;

    assign mismatch_count = mismatches;

    // Advance the mirrored state by one control tick and return its result
    function automatic tick_result_t slew_tick(input logic arrived, input logic [7:0] thr,
                                               input logic [31:0] now);
        tick_result_t res;
        logic [63:0]  step;
        logic [31:0]  elapsed;
        logic         power;
        int           target;
        int           cur;
        int           nxt;
        if (arrived) begin
            held_thr     = thr;
            last_byte_ms = now;
            silence_ms   = '0;
        end else begin
            silence_ms = now - last_byte_ms;
        end
        if (silence_ms > 32'(cfg.read_timeout_ms))
            held_thr = '0;
        power   = silence_ms < 32'(cfg.power_timeout_ms);
        elapsed = now - last_tick_ms;
        if (cfg.full_sweep_ms == '0) begin
            step = 64'd65535;
        end else begin
            step = (64'(elapsed) * 64'(cfg.command_range) + 64'(cfg.full_sweep_ms) - 64'd1)
                 / 64'(cfg.full_sweep_ms);
        end
        if (held_thr == '0)
            step = step * 64'(cfg.release_multiplier);
        if (step > 64'd65535)
            step = 64'd65535;
        target = int'(cfg.min_command) + (int'(held_thr) * int'(cfg.command_range)) / 255;
        cur    = int'(command);
        if (!power) begin
            nxt = int'(cfg.min_command);
        end else if (target > cur) begin
            nxt = cur + int'(step);
            if (nxt > target) nxt = target;
            if (nxt > int'(cfg.max_command)) nxt = int'(cfg.max_command);
        end else if (target < cur) begin
            nxt = cur - int'(step);
            if (nxt < target) nxt = target;
            if (nxt < int'(cfg.min_command)) nxt = int'(cfg.min_command);
        end else begin
            nxt = cur;
        end
        command      = nxt[7:0];
        last_tick_ms = now;
        res.command  = command;
        res.power    = power;
        res.held     = held_thr;
        return res;
    endfunction

    task automatic compare_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        tick_result_t want;
        tick_result_t got;
        if (!aresetn) begin
            cfg.read_timeout_ms    = RST_READ_TIMEOUT;
            cfg.power_timeout_ms   = RST_POWER_TIMEOUT;
            cfg.min_command        = RST_MIN_COMMAND;
            cfg.max_command        = RST_MAX_COMMAND;
            cfg.command_range      = RST_COMMAND_RANGE;
            cfg.full_sweep_ms      = RST_FULL_SWEEP;
            cfg.release_multiplier = RST_RELEASE_MULT;
            held_thr     = '0;
            last_byte_ms = '0;
            silence_ms   = '0;
            last_tick_ms = '0;
            command      = '0;
            pending_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_READ_TIMEOUT:  cfg.read_timeout_ms    = pwdata[15:0];
                    REG_POWER_TIMEOUT: cfg.power_timeout_ms   = pwdata[15:0];
                    REG_MIN_COMMAND:   cfg.min_command        = pwdata[7:0];
                    REG_MAX_COMMAND:   cfg.max_command        = pwdata[7:0];
                    REG_COMMAND_RANGE: cfg.command_range      = pwdata[7:0];
                    REG_FULL_SWEEP:    cfg.full_sweep_ms      = pwdata[15:0];
                    REG_RELEASE_MULT:  cfg.release_multiplier = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(slew_tick(s_tuser, s_tdata[7:0], s_tdata[39:8]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[16:0];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("motor_command", int'(want.command), int'(got.command));
                    compare_field("power_enable", int'(want.power), int'(got.power));
                    compare_field("held_throttle", int'(want.held), int'(got.held));
                end
            end
        end
        open_count <= pending_results.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the slew limiter testbench: clock, reset, stimulus, register writes and verdict.
// Depends on tls_pkg, the throttle_link_slew_limiter RTL and tls_checker.
module tb_top;
    import tls_pkg::*;

    localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int RANDOM_TICKS = 75;   // per phase
    localparam int PHASES = 8;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;   // [7:0] throttle_byte, [39:8] now_ms
    logic               s_tuser;   // [0] byte_arrived
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;   // [7:0] motor_command, [8] power_enable, [16:9] held_throttle
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int          mismatch_count;
    int          open_count;
    int          gap_pct = 0;      // chance per cycle that the sender sits idle
    int          stall_pct = 0;    // chance per cycle that the receiver stalls
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = '0;    // running millisecond time fed to the block

    throttle_link_slew_limiter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tls_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .open_count     (open_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: stall at random according to the current phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: give up once no handshake of any kind has happened for a long stretch
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one tick to the block and hold it until accepted; tvalid stays high after
    task automatic send_tick(input logic arrived, input logic [7:0] thr,
                             input logic [31:0] now);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, thr};
        s_tuser  <= arrived;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop tvalid and hold off until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_count != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_settings(input logic [15:0] rd_to, input logic [15:0] pw_to,
                                  input logic [7:0] min_cmd, input logic [7:0] max_cmd,
                                  input logic [7:0] range, input logic [15:0] sweep,
                                  input logic [3:0] mult);
        apb_write(REG_READ_TIMEOUT, 32'(rd_to));
        apb_write(REG_POWER_TIMEOUT, 32'(pw_to));
        apb_write(REG_MIN_COMMAND, 32'(min_cmd));
        apb_write(REG_MAX_COMMAND, 32'(max_cmd));
        apb_write(REG_COMMAND_RANGE, 32'(range));
        apb_write(REG_FULL_SWEEP, 32'(sweep));
        apb_write(REG_RELEASE_MULT, 32'(mult));
    endtask

    task automatic random_settings();
        logic [7:0] min_cmd;
        logic [7:0] max_cmd;
        // usually a sane window, sometimes anything, inverted limits included
        if ($urandom_range(3) == 0) begin
            min_cmd = 8'($urandom_range(0, 180));
            max_cmd = 8'($urandom_range(0, 180));
        end else begin
            min_cmd = 8'($urandom_range(0, 40));
            max_cmd = 8'($urandom_range(120, 180));
        end
        write_settings(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                       min_cmd, max_cmd,
                       8'($urandom_range(0, 180)), 16'($urandom_range(1, 4000)),
                       4'($urandom_range(1, 15)));
    endtask

    // One random control tick: mostly steady traffic, with silences and time jumps
    task automatic random_tick();
        int         kind;
        logic       arrived;
        logic [7:0] thr;
        kind = $urandom_range(99);
        if (kind < 65) begin
            clock_ms += $urandom_range(0, 40);
            arrived = ($urandom_range(9) != 0);
        end else if (kind < 82) begin
            clock_ms += $urandom_range(1, 30);
            arrived = 1'b0;
        end else if (kind < 96) begin
            clock_ms += $urandom_range(30, 3000);
            arrived = 1'($urandom_range(1));
        end else begin
            clock_ms += $urandom;
            arrived = 1'($urandom_range(1));
        end
        case ($urandom_range(9))
            0:       thr = 8'd0;
            1:       thr = 8'd255;
            default: thr = 8'($urandom);
        endcase
        send_tick(arrived, thr, clock_ms);
    endtask

    initial begin
        int phase;
        int n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks under the reset settings (read 500 ms, power 1000 ms)
        send_tick(1'b1, 8'd255, 32'd0);           // full throttle, no time elapsed
        send_tick(1'b1, 8'd255, 32'd10);
        send_tick(1'b0, 8'hAA, 32'd20);           // no byte: stored throttle holds
        send_tick(1'b1, 8'd0, 32'd40);            // throttle zero: release step
        send_tick(1'b1, 8'd128, 32'd100);
        send_tick(1'b1, 8'd128, 32'd1500);        // long elapsed time: slew hits target
        send_tick(1'b0, 8'h55, 32'd2000);         // silence equal to read timeout
        send_tick(1'b0, 8'h55, 32'd2001);         // one past it: throttle forced to zero
        send_tick(1'b0, 8'h00, 32'd2499);         // power still on just below timeout
        send_tick(1'b0, 8'hFF, 32'd2500);         // silence reaches power timeout: off
        send_tick(1'b1, 8'd200, 32'd2501);        // link back
        send_tick(1'b1, 8'd200, 32'd2501);        // same timestamp: zero step
        send_tick(1'b1, 8'd255, 32'hFFFF_FFF0);   // huge elapsed: step saturates
        send_tick(1'b1, 8'd1, 32'h0000_0005);     // time wraps
        send_tick(1'b1, 8'd254, 32'h0000_0006);
        send_tick(1'b0, 8'd0, 32'h8000_0000);     // silence across half the time range
        send_tick(1'b1, 8'd255, 32'hFFFF_FFFF);
        send_tick(1'b0, 8'd0, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFFF;
        drain_results();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1:       write_settings(16'd0, 16'd0, 8'd0, 8'd180, 8'd180, 16'd1, 4'd15);
                2:       write_settings(16'hFFFF, 16'hFFFF, 8'd180, 8'd0, 8'd0, 16'hFFFF, 4'd1);
                // zero sweep time slews instantly; zero multiplier freezes release
                3:       write_settings(16'($urandom_range(100, 2000)),
                                        16'($urandom_range(100, 3000)),
                                        8'd10, 8'd170, 8'd180, 16'd0, 4'd0);
                default: random_settings();
            endcase
            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 53; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 14; stall_pct = 14; end
            endcase
            for (n = 0; n < RANDOM_TICKS; n++) begin
                random_tick();
                // once per phase, hold the sender until the pipe is empty
                if (n == RANDOM_TICKS / 2)
                    drain_results();
            end
            drain_results();
        end

        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && open_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
